>>> hw/rtl/otp_pkg.sv
// Shared constants and types for the OTP page register controller.
package otp_pkg;

	localparam int PAGE_COUNT_DEF = 512;
	localparam int READ_BIT_DEF   = 12;
	localparam int WRITE_BIT_DEF  = 11;
	localparam int DONE_BIT_DEF   = 0;

	localparam int PAGE_BYTES   = 16;
	localparam int PAGE_BITS    = PAGE_BYTES * 8;
	localparam int PAGE_FIELD_W = 9;

	localparam logic [15:0] CTRL_MASK    = 16'h39FF;
	localparam logic [15:0] BEN_RESET    = 16'hFFFF;
	localparam logic [31:0] TIMING_RESET = 32'h0000_1485;

	// register offsets
	localparam logic [7:0] OFF_CTRL   = 8'd0;
	localparam logic [7:0] OFF_BEN    = 8'd4;
	localparam logic [7:0] OFF_STAT   = 8'd8;
	localparam logic [7:0] OFF_TIMING = 8'd12;
	localparam logic [7:0] OFF_DATA0  = 8'd128;
	localparam logic [7:0] OFF_DATA1  = 8'd132;
	localparam logic [7:0] OFF_DATA2  = 8'd136;
	localparam logic [7:0] OFF_DATA3  = 8'd140;

	localparam logic [2:0] SIZE_NONE = 3'd0;
	localparam logic [2:0] SIZE_16   = 3'd2;
	localparam logic [2:0] SIZE_32   = 3'd4;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_SIZE     = 2'd1;
	localparam logic [1:0] ERR_UNMAPPED = 2'd2;

	typedef struct packed {
		logic                  wr;
		logic                  rd;
		logic [PAGE_BYTES-1:0] ben;
	} otp_mem_cmd_t;

endpackage

>>> hw/rtl/otp_page_mem.sv
// Page memory: one 128-bit row per page, byte write enables, registered read.
module otp_page_mem import otp_pkg::*; #(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF,
	localparam int AW = $clog2(PAGE_COUNT)
) (
	input  logic                 clk,
	input  otp_mem_cmd_t         cmd,
	input  logic [AW-1:0]        addr,
	input  logic [PAGE_BITS-1:0] wdata,
	output logic [PAGE_BITS-1:0] rdata_s1
);

	logic [PAGE_BITS-1:0] page_mem_q [PAGE_COUNT];

	always_ff @(posedge clk) begin
		for (int b = 0; b < PAGE_BYTES; b++) begin
			if (cmd.wr && cmd.ben[b])
				page_mem_q[addr][b*8 +: 8] <= wdata[b*8 +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd)
			rdata_s1 <= page_mem_q[addr];
	end

endmodule

>>> hw/rtl/otp_page_mod.sv
// Reduction of the 9-bit page field modulo the page count by reciprocal multiplication.
module otp_page_mod import otp_pkg::*; #(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF,
	localparam int AW = $clog2(PAGE_COUNT)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [PAGE_FIELD_W-1:0] value,
	output logic                    done,
	output logic [AW-1:0]           page
);

	localparam int RECIP_SH = 20;
	localparam int PROD_W   = PAGE_FIELD_W + RECIP_SH;
	localparam int QP_W     = 2 * PAGE_FIELD_W + 1;
	// ceil(2^20 / PAGE_COUNT) gives the exact quotient for every 9-bit value
	localparam logic [RECIP_SH-1:0] RECIP =
		RECIP_SH'(((1 << RECIP_SH) + PAGE_COUNT - 1) / PAGE_COUNT);

	logic                    busy_q;
	logic [PAGE_FIELD_W-1:0] r_q;
	logic [PAGE_FIELD_W-1:0] quo_q;
	logic [PROD_W-1:0]       prod_w;
	logic [QP_W-1:0]         qp_w;
	logic [PAGE_FIELD_W-1:0] rem_w;

	// quotient taken at start, remainder formed in the following cycle
	assign prod_w = PROD_W'(value) * PROD_W'(RECIP);
	assign qp_w   = QP_W'(quo_q) * QP_W'(PAGE_COUNT);
	assign rem_w  = r_q - qp_w[PAGE_FIELD_W-1:0];

	assign done = busy_q;
	assign page = rem_w[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else
			busy_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= value;
			quo_q <= prod_w[PROD_W-1:RECIP_SH];
		end
	end

endmodule

>>> hw/rtl/otp_page_register_controller.sv
// Every access returns its beat in the cycle after acceptance, from registers.
// Register reads and writes are accepted every cycle while the output is free and no page transfer or clear runs.
// A control write holds off input while the page is looked up and accessed (S_MOD),
// and through S_RDWAIT as well when it loads the data words from the page.
// Reset: registers take their reset values at once; the page memory is then
// zeroed one page per cycle, every page in turn, with input held off.
module otp_page_register_controller import otp_pkg::*; #(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF,
	parameter int READ_BIT   = READ_BIT_DEF,
	parameter int WRITE_BIT  = WRITE_BIT_DEF,
	parameter int DONE_BIT   = DONE_BIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  offset,
	input  logic [2:0]  size_bytes,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [1:0]  error
);

	localparam int AW = $clog2(PAGE_COUNT);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_RDWAIT} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	logic          wbit_q;
	logic          rbit_q;

	logic [15:0] control_q;
	logic [15:0] ben_q;
	logic [15:0] status_q;
	logic [31:0] timing_q;
	logic [31:0] data_q [4];

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [1:0]  error_q;

	logic        accept;
	logic [2:0]  need;
	logic [1:0]  err_w;
	logic [31:0] rd_w;
	logic [1:0]  didx;
	logic        ctrl_wr;

	logic                 mod_done;
	logic [AW-1:0]        mod_page;
	otp_mem_cmd_t         mem_cmd;
	logic [AW-1:0]        mem_addr;
	logic [PAGE_BITS-1:0] mem_wdata;
	logic [PAGE_BITS-1:0] mem_rdata_s1;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign error     = error_q;
	assign didx      = offset[3:2];

	always_comb begin
		case (offset)
			OFF_CTRL, OFF_BEN, OFF_STAT:                         need = SIZE_16;
			OFF_TIMING, OFF_DATA0, OFF_DATA1, OFF_DATA2, OFF_DATA3: need = SIZE_32;
			default:                                              need = SIZE_NONE;
		endcase
		if (need == SIZE_NONE)
			err_w = ERR_UNMAPPED;
		else if (size_bytes != need)
			err_w = ERR_SIZE;
		else
			err_w = ERR_OK;
	end

	always_comb begin
		case (offset)
			OFF_CTRL:   rd_w = {16'h0, control_q};
			OFF_BEN:    rd_w = {16'h0, ben_q};
			OFF_STAT:   rd_w = {16'h0, status_q};
			OFF_TIMING: rd_w = timing_q;
			default:    rd_w = data_q[didx];
		endcase
		if (kind || err_w != ERR_OK)
			rd_w = '0;
	end

	assign ctrl_wr = accept && kind && (err_w == ERR_OK) && (offset == OFF_CTRL);

	// memory port: clear sweep, or the page transfer once the page is known
	always_comb begin
		mem_cmd   = '0;
		mem_addr  = mod_page;
		mem_wdata = {data_q[3], data_q[2], data_q[1], data_q[0]};
		if (state_q == S_CLEAR) begin
			mem_cmd.wr  = 1'b1;
			mem_cmd.ben = '1;
			mem_addr    = clr_cnt_q;
			mem_wdata   = '0;
		end else if (state_q == S_MOD && mod_done) begin
			mem_cmd.ben = ben_q;
			mem_cmd.wr  = wbit_q;
			mem_cmd.rd  = rbit_q && !wbit_q;
		end
	end

	otp_page_mod #(.PAGE_COUNT(PAGE_COUNT)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl_wr),
		.value  (write_data[PAGE_FIELD_W-1:0]),
		.done   (mod_done),
		.page   (mod_page)
	);

	otp_page_mem #(.PAGE_COUNT(PAGE_COUNT)) u_mem (
		.clk      (clk),
		.cmd      (mem_cmd),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.rdata_s1 (mem_rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			wbit_q      <= 1'b0;
			rbit_q      <= 1'b0;
			control_q   <= '0;
			ben_q       <= BEN_RESET;
			status_q    <= '0;
			timing_q    <= TIMING_RESET;
			for (int i = 0; i < 4; i++)
				data_q[i] <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			error_q     <= ERR_OK;
		end else begin
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(PAGE_COUNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						// the beat is known at acceptance; a page transfer runs after
						read_data_q <= rd_w;
						error_q     <= err_w;
						if (kind && err_w == ERR_OK) begin
							case (offset)
								OFF_CTRL: begin
									control_q          <= write_data[15:0] & CTRL_MASK;
									status_q[DONE_BIT] <= 1'b1;
									wbit_q             <= write_data[WRITE_BIT];
									rbit_q             <= write_data[READ_BIT];
									state_q            <= S_MOD;
								end
								OFF_BEN:    ben_q    <= write_data[15:0];
								OFF_STAT:   status_q <= status_q & ~write_data[15:0];
								OFF_TIMING: timing_q <= write_data;
								default:    data_q[didx] <= write_data;
							endcase
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						// write then read back leaves the data words unchanged
						if (rbit_q && !wbit_q)
							state_q <= S_RDWAIT;
						else
							state_q <= S_IDLE;
					end
				end
				S_RDWAIT: begin
					for (int b = 0; b < PAGE_BYTES; b++) begin
						if (ben_q[b])
							data_q[b/4][(b%4)*8 +: 8] <= mem_rdata_s1[b*8 +: 8];
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/otp_chk.sv
// Port-level checker for the OTP page register controller, with its bind.
module otp_chk import otp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        kind,
	input logic [7:0]  offset,
	input logic [2:0]  size_bytes,
	input logic [31:0] write_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic [1:0]  error
);

	// every accepted beat shows up on the output in the next cycle
	a_resp_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no response after accepted beat");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> read_data == 32'h0)
		else $error("write access returned nonzero data");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != ERR_OK |-> read_data == 32'h0 && error != 2'd3)
		else $error("error beat carries data or bad code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(error))
		else $error("stalled output beat changed");

endmodule

bind otp_page_register_controller otp_chk u_otp_chk (.*);
